// ----- rtl/lrss_pkg.sv -----
// Shared types and constants for the loco refresh slot scheduler.
// No dependencies; used by every module of the block but the divider.
package lrss_pkg;

    localparam int SLOT_COUNT = 128;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_LOCO  = 3'd1;
    localparam logic [2:0] MODE_FUNC  = 3'd2;
    localparam logic [2:0] MODE_PON   = 3'd3;
    localparam logic [2:0] MODE_POFF  = 3'd4;
    localparam logic [2:0] MODE_SHORT = 3'd5;

    localparam logic [3:0] PK_IDLE  = 4'd0;
    localparam logic [3:0] PK_S128  = 4'd1;
    localparam logic [3:0] PK_S28   = 4'd2;
    localparam logic [3:0] PK_S14   = 4'd3;
    localparam logic [3:0] PK_FG1   = 4'd4;
    localparam logic [3:0] PK_FG2   = 4'd5;
    localparam logic [3:0] PK_FG3   = 4'd6;
    localparam logic [3:0] PK_FG4   = 4'd7;
    localparam logic [3:0] PK_FG5   = 4'd8;
    localparam logic [3:0] PK_POWER = 4'd9;

    localparam logic [15:0] TIMEOUT_RESET = 16'd8000;
    localparam logic [7:0]  SHORT_RESET   = 8'd10;
    localparam logic [7:0]  PCT_DIV       = 8'd100;
    localparam logic [6:0]  SPEED_MAX     = 7'd127;
    localparam logic [7:0]  COUNT_MAX     = 8'hFF;

    localparam int REG_TIMEOUT = 0;
    localparam int REG_SHORT   = 1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now_ms;
        logic [13:0] loco_address;
        logic        long_protocol;
        logic [15:0] speed_request;
        logic        speed_is_percent;
        logic [14:0] speed_max;
        logic [7:0]  step_count;
        logic        direction;
        logic [28:0] function_bits;
        logic [2:0]  function_group;
        logic        short_sense;
    } item_t;

    // One slot entry as held in the slot memory.
    typedef struct packed {
        logic [13:0] address;
        logic [2:0]  flags;
        logic [6:0]  speed;
        logic [6:0]  prev_speed;
        logic [7:0]  steps;
        logic [28:0] fbits;
        logic [3:0]  changed;
        logic [3:0]  active;
        logic [31:0] stamp;
    } slot_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [13:0] address;
        logic        long_addr;
        logic [6:0]  speed;
        logic        dir;
        logic        lights;
        logic [28:0] fbits;
        logic        power;
        logic        last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        clear_step;  // write zero to entry clr_idx
        logic        rd_en;       // read entry rd_idx
        logic        div_start;
        logic        commit;      // apply update to looked-up slot
        logic        refresh;     // apply refresh update to slot
        logic        purge;
    } cmd_t;

    typedef struct packed {
        logic        div_busy;
        logic        hit;         // current read entry matches or is empty
        logic        empty;       // current read entry has address 0
        logic        fresh;       // speed unchanged and no changed group
        logic        expired;
    } sts_t;

endpackage

// ----- rtl/lrss_divider.sv -----
// Restoring divider, one quotient bit a cycle, for speed scaling.
// No dependencies.
module lrss_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [22:0] dividend,
    input  logic [14:0] divisor,
    output logic        busy,
    output logic [22:0] quotient
);

    logic [4:0]  count_reg, count_next;
    logic [22:0] q_reg, q_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] trial;

    assign trial = {rem_reg[14:0], q_reg[22]};

    always_comb
    begin
        count_next = count_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            count_next = 5'd23;
            q_next     = dividend;
            rem_next   = '0;
        end
        else if (count_reg != 5'd0)
        begin
            count_next = count_reg - 5'd1;
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                q_next   = {q_reg[21:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[21:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign busy     = (count_reg != 5'd0);
    assign quotient = q_reg;

endmodule

// ----- rtl/lrss_datapath.sv -----
// Slot memory, speed scaling, slot timeout check.
// Depends on lrss_pkg and lrss_divider.
module lrss_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lrss_pkg::cmd_t                 cmd,
    input  logic [lrss_pkg::SLOT_W-1:0]    clr_idx,
    input  logic [lrss_pkg::SLOT_W-1:0]    rd_idx,
    input  lrss_pkg::item_t                item,
    input  logic [15:0]                    timeout,
    output lrss_pkg::sts_t                 sts,
    output lrss_pkg::slot_t                slot_q
);

    lrss_pkg::slot_t mem [lrss_pkg::SLOT_COUNT];
    lrss_pkg::slot_t rd_reg;
    logic [lrss_pkg::SLOT_W-1:0] idx_reg;
    logic        wr_en;
    lrss_pkg::slot_t wr_data;
    logic [lrss_pkg::SLOT_W-1:0] wr_idx;

    logic [22:0] prod;
    logic [14:0] divisor;
    logic [22:0] quot;
    logic        div_busy;
    logic [6:0]  speed;
    logic        no_speed;
    logic        f0;
    logic        long_bit;
    logic [32:0] deadline;

    // 16 x 8 product, divided by 100 or by speed_max.
    assign prod    = {7'd0, item.speed_request} * {15'd0, item.step_count};
    assign divisor = item.speed_is_percent ? {7'd0, lrss_pkg::PCT_DIV} : item.speed_max;
    assign no_speed = item.speed_request[15] ||
                      (!item.speed_is_percent && item.speed_max == 15'd0);

    lrss_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign speed = no_speed ? 7'd0 :
                   (quot > 23'd127) ? lrss_pkg::SPEED_MAX : quot[6:0];
    assign f0    = item.function_bits[0];
    assign long_bit = (item.loco_address > 14'd127);
    assign deadline = {1'b0, rd_reg.stamp} + {17'd0, timeout};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = idx_reg;
        wr_data = rd_reg;
        if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_idx  = clr_idx;
            wr_data = '0;
        end
        else if (cmd.commit)
        begin
            wr_en = 1'b1;
            if (item.mode == lrss_pkg::MODE_LOCO)
            begin
                wr_data.speed   = speed;
                wr_data.steps   = item.step_count;
                wr_data.address = item.loco_address;
                wr_data.flags   = {f0, long_bit | item.long_protocol, item.direction};
                wr_data.fbits   = {rd_reg.fbits[28:1], f0};
                wr_data.changed = f0 ? 4'd1 : 4'hF;
                wr_data.stamp   = item.now_ms;
            end
            else
            begin
                if (rd_reg.address == 14'd0)
                begin
                    wr_data.address  = item.loco_address;
                    wr_data.flags[1] = long_bit;
                end
                wr_data.changed  = {1'b0, item.function_group};
                wr_data.flags[2] = f0;
                wr_data.fbits    = item.function_bits;
            end
        end
        else if (cmd.purge)
        begin
            wr_en              = 1'b1;
            wr_data.address    = '0;
            wr_data.stamp      = '0;
            wr_data.active     = '0;
            wr_data.changed    = '0;
            wr_data.prev_speed = '0;
            wr_data.speed      = '0;
        end
        else if (cmd.refresh)
        begin
            wr_en              = 1'b1;
            wr_data.prev_speed = rd_reg.speed;
            wr_data.active     = rd_reg.changed;
            wr_data.changed    = '0;
            wr_data.stamp      = item.now_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        if (cmd.rd_en)
        begin
            rd_reg  <= mem[rd_idx];
            idx_reg <= rd_idx;
        end
        else if (wr_en && !cmd.clear_step)
            rd_reg  <= wr_data;
    end

    assign sts.div_busy = div_busy;
    assign sts.empty    = (rd_reg.address == 14'd0);
    assign sts.hit      = (rd_reg.address == item.loco_address) || sts.empty;
    assign sts.fresh    = (rd_reg.speed == rd_reg.prev_speed) && (rd_reg.changed == 4'd0);
    assign sts.expired  = (deadline < {1'b0, item.now_ms});
    assign slot_q       = rd_reg;

endmodule

// ----- rtl/lrss_controller.sv -----
// Sequencing state machine: clearing pass, slot search, refresh, power and short state, results.
// Depends on lrss_pkg.
module lrss_controller
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lrss_pkg::item_t             item_in,
    output lrss_pkg::item_t             item,
    input  lrss_pkg::sts_t              sts,
    input  lrss_pkg::slot_t             slot_q,
    input  logic [7:0]                  short_limit,
    output lrss_pkg::cmd_t              cmd,
    output logic [lrss_pkg::SLOT_W-1:0] clr_idx,
    output logic [lrss_pkg::SLOT_W-1:0] rd_idx,
    output logic                        out_valid,
    input  logic                        out_ready,
    output lrss_pkg::result_t           result
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_COMMIT = 4'd5;
    localparam logic [3:0] S_RCHECK = 4'd6;
    localparam logic [3:0] S_EMIT1  = 4'd7;
    localparam logic [3:0] S_EMIT2  = 4'd8;
    localparam logic [3:0] S_DIVW   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [lrss_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [lrss_pkg::SLOT_W-1:0] rix_reg, rix_next;
    logic power_reg, power_next;
    logic [7:0] scount_reg, scount_next;
    logic seen_reg, seen_next;
    lrss_pkg::item_t item_reg;
    logic ovalid_reg, ovalid_next;
    lrss_pkg::result_t res_reg, res_next;
    logic accept;
    logic last_slot;
    logic [3:0] gkind;

    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign accept    = in_valid && in_ready;
    assign item      = item_reg;
    assign out_valid = ovalid_reg;
    assign result    = res_reg;
    assign clr_idx   = cnt_reg[lrss_pkg::SLOT_W-1:0];
    assign last_slot = (cnt_reg == lrss_pkg::CNT_W'(lrss_pkg::SLOT_COUNT - 1));

    always_comb
    begin
        unique case (slot_q.active)
            4'd1:        gkind = lrss_pkg::PK_FG1;
            4'd2:        gkind = lrss_pkg::PK_FG2;
            4'd3:        gkind = lrss_pkg::PK_FG3;
            4'd4, 4'd5:  gkind = lrss_pkg::PK_FG4;
            default:     gkind = lrss_pkg::PK_FG5;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rix_next    = rix_reg;
        power_next  = power_reg;
        scount_next = scount_reg;
        seen_next   = seen_reg;
        ovalid_next = ovalid_reg && !out_ready;
        res_next    = res_reg;
        cmd         = '0;
        rd_idx      = cnt_reg[lrss_pkg::SLOT_W-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (last_slot)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    unique case (item_in.mode)
                        lrss_pkg::MODE_TICK:
                            if (power_reg)
                                state_next = S_READ;
                        lrss_pkg::MODE_LOCO, lrss_pkg::MODE_FUNC:
                            state_next = S_READ;
                        lrss_pkg::MODE_PON, lrss_pkg::MODE_POFF:
                        begin
                            power_next  = (item_in.mode == lrss_pkg::MODE_PON);
                            res_next    = '0;
                            res_next.kind  = lrss_pkg::PK_POWER;
                            res_next.power = power_next;
                            res_next.last  = 1'b1;
                            ovalid_next = 1'b1;
                        end
                        lrss_pkg::MODE_SHORT:
                            if (power_reg)
                            begin
                                if (item_in.short_sense)
                                begin
                                    if (seen_reg && scount_reg > short_limit)
                                    begin
                                        scount_next = '0;
                                        seen_next   = 1'b0;
                                        power_next  = 1'b0;
                                        res_next    = '0;
                                        res_next.kind = lrss_pkg::PK_POWER;
                                        res_next.last = 1'b1;
                                        ovalid_next = 1'b1;
                                    end
                                    else
                                    begin
                                        if (scount_reg != lrss_pkg::COUNT_MAX)
                                            scount_next = scount_reg + 8'd1;
                                        seen_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    scount_next = '0;
                                    seen_next   = 1'b0;
                                end
                            end
                        default: ;
                    endcase
                end
            end
            S_READ:
            begin
                cmd.rd_en = 1'b1;
                if (item_reg.mode == lrss_pkg::MODE_TICK)
                begin
                    rd_idx     = rix_reg;
                    state_next = S_RCHECK;
                end
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.hit)
                begin
                    if (item_reg.mode == lrss_pkg::MODE_LOCO)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIVW;
                    end
                    else
                        state_next = S_COMMIT;
                end
                else if (last_slot)
                    state_next = S_IDLE;
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_DIVW:
                state_next = S_DIV;
            S_DIV:
                if (!sts.div_busy)
                    state_next = S_COMMIT;
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            S_RCHECK:
            begin
                if (sts.empty)
                begin
                    if (rix_reg == '0)
                    begin
                        res_next       = '0;
                        res_next.kind  = lrss_pkg::PK_IDLE;
                        res_next.power = power_reg;
                        res_next.last  = 1'b1;
                        ovalid_next    = 1'b1;
                    end
                    rix_next   = '0;
                    state_next = S_IDLE;
                end
                else if (sts.fresh && sts.expired)
                begin
                    cmd.purge  = 1'b1;
                    rix_next   = rix_reg + 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.refresh = !sts.fresh;
                    state_next  = S_EMIT1;
                end
            end
            S_EMIT1:
            begin
                if (!ovalid_reg)
                begin
                    res_next.kind = (slot_q.steps == 8'd128) ? lrss_pkg::PK_S128 :
                                    (slot_q.steps == 8'd28)  ? lrss_pkg::PK_S28 :
                                                               lrss_pkg::PK_S14;
                    res_next.address   = slot_q.address;
                    res_next.long_addr = slot_q.flags[1];
                    res_next.speed     = slot_q.speed;
                    res_next.dir       = slot_q.flags[0];
                    res_next.lights    = slot_q.flags[2];
                    res_next.fbits     = slot_q.fbits;
                    res_next.power     = power_reg;
                    res_next.last      = slot_q.active[3] || slot_q.active == 4'd0;
                    ovalid_next        = 1'b1;
                    if (res_next.last)
                    begin
                        rix_next   = rix_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_EMIT2;
                end
            end
            S_EMIT2:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    res_next.kind = gkind;
                    res_next.last = 1'b1;
                    ovalid_next   = 1'b1;
                    rix_next      = rix_reg + 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cnt_reg    <= '0;
            rix_reg    <= '0;
            power_reg  <= 1'b0;
            scount_reg <= '0;
            seen_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rix_reg    <= rix_next;
            power_reg  <= power_next;
            scount_reg <= scount_next;
            seen_reg   <= seen_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
            item_reg <= item_in;
    end

endmodule

// ----- rtl/loco_refresh_slot_scheduler.sv -----
// Top level of the loco refresh slot scheduler: stream ports, APB registers.
// Depends on lrss_pkg, lrss_controller and lrss_datapath.
//
// The block keeps a 128-entry locomotive slot table in a single-port memory.
// After reset a clearing pass writes every slot to empty, one per cycle, so
// no word is taken until the pass is done. A loco or function command
// searches the table one slot at a time, read then checked, for the first
// matching or empty slot; a loco command then runs the serial speed divider.
// A refresh tick, with power on, reads one slot and emits its speed word,
// then a function group word if one is active; an expired unchanged slot is
// purged instead, and an empty one restarts the sweep. One word is worked
// on at a time; a new word is taken once the result register is free.
// Result words carry last on the final word of each input word.
module loco_refresh_slot_scheduler
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode(3), now_ms(32), loco_address(14), long_protocol(1),
    // speed_request(16), speed_is_percent(1), speed_max(15), step_count(8),
    // direction(1), function_bits(29), function_group(3), short_sense(1); 128 bits
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // packet_kind(4), out_address(14), out_long_address(1), out_speed(7),
    // out_direction(1), out_lights(1), out_functions(29), power_on(1); 64 bits
    output logic [63:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    lrss_pkg::item_t   item_in;
    lrss_pkg::item_t   item;
    lrss_pkg::cmd_t    cmd;
    lrss_pkg::sts_t    sts;
    lrss_pkg::slot_t   slot_q;
    lrss_pkg::result_t result;
    logic [lrss_pkg::SLOT_W-1:0] clr_idx;
    logic [lrss_pkg::SLOT_W-1:0] rd_idx;
    logic [15:0] timeout_reg;
    logic [7:0]  limit_reg;
    logic        wr;

    assign item_in.mode             = s_axis_tdata[2:0];
    assign item_in.now_ms           = s_axis_tdata[34:3];
    assign item_in.loco_address     = s_axis_tdata[48:35];
    assign item_in.long_protocol    = s_axis_tdata[49];
    assign item_in.speed_request    = s_axis_tdata[65:50];
    assign item_in.speed_is_percent = s_axis_tdata[66];
    assign item_in.speed_max        = s_axis_tdata[81:67];
    assign item_in.step_count       = s_axis_tdata[89:82];
    assign item_in.direction        = s_axis_tdata[90];
    assign item_in.function_bits    = s_axis_tdata[119:91];
    assign item_in.function_group   = s_axis_tdata[122:120];
    assign item_in.short_sense      = s_axis_tdata[123];

    // Configuration registers; register i at byte address 4*i.
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= lrss_pkg::TIMEOUT_RESET;
            limit_reg   <= lrss_pkg::SHORT_RESET;
        end
        else if (wr)
        begin
            if (paddr == 3'(4 * lrss_pkg::REG_TIMEOUT))
                timeout_reg <= pwdata[15:0];
            else if (paddr == 3'(4 * lrss_pkg::REG_SHORT))
                limit_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr == 3'(4 * lrss_pkg::REG_TIMEOUT))
            prdata = {16'd0, timeout_reg};
        else if (paddr == 3'(4 * lrss_pkg::REG_SHORT))
            prdata = {24'd0, limit_reg};
        else
            prdata = '0;
    end

    lrss_controller u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .item_in     (item_in),
        .item        (item),
        .sts         (sts),
        .slot_q      (slot_q),
        .short_limit (limit_reg),
        .cmd         (cmd),
        .clr_idx     (clr_idx),
        .rd_idx      (rd_idx),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .result      (result)
    );

    lrss_datapath u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .clr_idx (clr_idx),
        .rd_idx  (rd_idx),
        .item    (item),
        .timeout (timeout_reg),
        .sts     (sts),
        .slot_q  (slot_q)
    );

    assign m_axis_tdata = {6'd0, result.power, result.fbits, result.lights, result.dir,
                           result.speed, result.long_addr, result.address, result.kind};
    assign m_axis_tlast = result.last;

endmodule

// ----- rtl/lrss_checker.sv -----
// Port-level assertions for the loco refresh slot scheduler, with bind.
// Depends on lrss_pkg for the packet kind codes.
module lrss_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Power status words are always single and final.
    a_power_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] == lrss_pkg::PK_POWER |-> m_axis_tlast)
        else $error("power status word without last");

    // A function group word always closes its run.
    a_group_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] >= lrss_pkg::PK_FG1 &&
        m_axis_tdata[3:0] <= lrss_pkg::PK_FG5 |-> m_axis_tlast)
        else $error("function word without last");

    // No new input is taken while a result waits.
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

endmodule

bind loco_refresh_slot_scheduler lrss_checker u_lrss_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- test/loco_refresh_slot_scheduler_test.sv -----
// Self-checking testbench for the loco refresh slot scheduler: stream words in and out,
// APB register writes, and a behavioural slot table that predicts every result word.
// Depends on lrss_pkg and the loco_refresh_slot_scheduler top level.
module loco_refresh_slot_scheduler_test;

    // Predicted result word, in the order of the packed output fields.
    typedef struct {
        logic [3:0]  kind;
        logic [13:0] address;
        logic        long_addr;
        logic [6:0]  speed;
        logic        dir;
        logic        lights;
        logic [28:0] fbits;
        logic        power;
        logic        last;
        bit          has_known;
        logic [3:0]  known_kind;
    } packet_t;

    // One row of the directed table. The expected kind is only checked where
    // the row gives one; every row is also run through the predictor.
    typedef struct {
        lrss_pkg::item_t cmd;
        logic [3:0]      known_kind;
        bit              has_known;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    loco_refresh_slot_scheduler DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Predictor copy of the slot table and the block's scalar state.
    logic [13:0] tab_addr [lrss_pkg::SLOT_COUNT];
    logic [2:0]  tab_flags [lrss_pkg::SLOT_COUNT];
    logic [6:0]  tab_speed [lrss_pkg::SLOT_COUNT];
    logic [6:0]  tab_prev [lrss_pkg::SLOT_COUNT];
    logic [7:0]  tab_steps [lrss_pkg::SLOT_COUNT];
    logic [28:0] tab_fn [lrss_pkg::SLOT_COUNT];
    int          tab_changed [lrss_pkg::SLOT_COUNT];
    int          tab_active [lrss_pkg::SLOT_COUNT];
    logic [31:0] tab_stamp [lrss_pkg::SLOT_COUNT];
    int          sweep_idx;
    bit          power_state;
    int          short_run;
    bit          short_armed;
    logic [15:0] timeout_reg;
    logic [7:0]  short_limit_reg;

    packet_t     pending_packets[$];
    int          error_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    localparam int WATCHDOG_LIMIT = 20000;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic packet_t slot_packet(input logic [3:0] kind, input int s);
        packet_t p;
        p.kind = kind;
        p.power = power_state;
        p.last = 1'b0;
        p.has_known = 1'b0;
        p.known_kind = lrss_pkg::PK_IDLE;
        if (s >= 0)
        begin
            p.address = tab_addr[s];
            p.long_addr = tab_flags[s][1];
            p.speed = tab_speed[s];
            p.dir = tab_flags[s][0];
            p.lights = tab_flags[s][2];
            p.fbits = tab_fn[s];
        end
        else
        begin
            p.address = '0;
            p.long_addr = 1'b0;
            p.speed = '0;
            p.dir = 1'b0;
            p.lights = 1'b0;
            p.fbits = '0;
        end
        return p;
    endfunction

    function automatic int lookup_slot(input logic [13:0] a);
        for (int i = 0; i < lrss_pkg::SLOT_COUNT; i++)
        begin
            if (tab_addr[i] == a || tab_addr[i] == 0)
                return i;
        end
        return -1;
    endfunction

    task automatic clear_table();
        for (int i = 0; i < lrss_pkg::SLOT_COUNT; i++)
        begin
            tab_addr[i] = '0;
            tab_flags[i] = '0;
            tab_speed[i] = '0;
            tab_prev[i] = '0;
            tab_steps[i] = '0;
            tab_fn[i] = '0;
            tab_changed[i] = 0;
            tab_active[i] = 0;
            tab_stamp[i] = '0;
        end
        sweep_idx = 0;
        power_state = 1'b0;
        short_run = 0;
        short_armed = 1'b0;
        timeout_reg = lrss_pkg::TIMEOUT_RESET;
        short_limit_reg = lrss_pkg::SHORT_RESET;
    endtask

    // Works out the result words that one command word causes and queues them.
    task automatic predict_packets(input lrss_pkg::item_t c, input bit has_known,
                                   input logic [3:0] known_kind);
        packet_t outs[$];
        int      s;
        int      idx;
        int      g;
        logic [31:0] v;
        logic [3:0]  kind;
        unique case (c.mode)
            lrss_pkg::MODE_TICK:
            begin
                idx = sweep_idx;
                if (power_state)
                begin
                    if (tab_addr[idx] == 0)
                    begin
                        // An empty slot restarts the sweep; only slot 0 sends an idle packet.
                        if (idx == 0)
                            outs.push_back(slot_packet(lrss_pkg::PK_IDLE, -1));
                        sweep_idx = 0;
                    end
                    else
                    begin
                        bit purged;
                        purged = 1'b0;
                        if (tab_speed[idx] == tab_prev[idx] && tab_changed[idx] == 0)
                        begin
                            if ({1'b0, tab_stamp[idx]} + 33'(timeout_reg) < {1'b0, c.now_ms})
                            begin
                                tab_addr[idx] = '0;
                                tab_stamp[idx] = '0;
                                tab_active[idx] = 0;
                                tab_changed[idx] = 0;
                                tab_prev[idx] = '0;
                                tab_speed[idx] = '0;
                                purged = 1'b1;
                            end
                        end
                        else
                        begin
                            tab_prev[idx] = tab_speed[idx];
                            tab_active[idx] = tab_changed[idx];
                            tab_changed[idx] = 0;
                            tab_stamp[idx] = c.now_ms;
                        end
                        if (!purged)
                        begin
                            if (tab_steps[idx] == 128)
                                kind = lrss_pkg::PK_S128;
                            else if (tab_steps[idx] == 28)
                                kind = lrss_pkg::PK_S28;
                            else
                                kind = lrss_pkg::PK_S14;
                            outs.push_back(slot_packet(kind, idx));
                            g = tab_active[idx];
                            if (g > 0)
                            begin
                                if (g == 1)
                                    kind = lrss_pkg::PK_FG1;
                                else if (g == 2)
                                    kind = lrss_pkg::PK_FG2;
                                else if (g == 3)
                                    kind = lrss_pkg::PK_FG3;
                                else if (g == 4 || g == 5)
                                    kind = lrss_pkg::PK_FG4;
                                else
                                    kind = lrss_pkg::PK_FG5;
                                outs.push_back(slot_packet(kind, idx));
                            end
                        end
                        sweep_idx = (idx + 1) % lrss_pkg::SLOT_COUNT;
                    end
                end
            end
            lrss_pkg::MODE_LOCO:
            begin
                s = lookup_slot(c.loco_address);
                if (s >= 0)
                begin
                    v = '0;
                    if (!c.speed_request[15])
                    begin
                        if (c.speed_is_percent)
                            v = (32'(c.speed_request) * 32'(c.step_count)) / 100;
                        else if (c.speed_max != 0)
                            v = (32'(c.speed_request) * 32'(c.step_count)) / 32'(c.speed_max);
                    end
                    if (v > 127)
                        v = 32'd127;
                    tab_speed[s] = v[6:0];
                    tab_steps[s] = c.step_count;
                    tab_addr[s] = c.loco_address;
                    tab_flags[s] = {c.function_bits[0],
                                    (c.loco_address > 127) || c.long_protocol,
                                    c.direction};
                    tab_fn[s] = {tab_fn[s][28:1], c.function_bits[0]};
                    tab_changed[s] = c.function_bits[0] ? 1 : -1;
                    tab_stamp[s] = c.now_ms;
                end
            end
            lrss_pkg::MODE_FUNC:
            begin
                s = lookup_slot(c.loco_address);
                if (s >= 0)
                begin
                    if (tab_addr[s] == 0)
                    begin
                        tab_addr[s] = c.loco_address;
                        tab_flags[s][1] = c.loco_address > 127;
                    end
                    tab_changed[s] = int'(c.function_group);
                    tab_flags[s][2] = c.function_bits[0];
                    tab_fn[s] = c.function_bits;
                end
            end
            lrss_pkg::MODE_PON:
            begin
                power_state = 1'b1;
                outs.push_back(slot_packet(lrss_pkg::PK_POWER, -1));
            end
            lrss_pkg::MODE_POFF:
            begin
                power_state = 1'b0;
                outs.push_back(slot_packet(lrss_pkg::PK_POWER, -1));
            end
            lrss_pkg::MODE_SHORT:
            begin
                if (power_state)
                begin
                    if (c.short_sense)
                    begin
                        if (short_armed && short_run > short_limit_reg)
                        begin
                            short_run = 0;
                            short_armed = 1'b0;
                            power_state = 1'b0;
                            outs.push_back(slot_packet(lrss_pkg::PK_POWER, -1));
                        end
                        else
                        begin
                            if (short_run < lrss_pkg::COUNT_MAX)
                                short_run++;
                            short_armed = 1'b1;
                        end
                    end
                    else
                    begin
                        short_run = 0;
                        short_armed = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (outs.size() > 0)
        begin
            outs[outs.size() - 1].last = 1'b1;
            outs[outs.size() - 1].has_known = has_known;
            outs[outs.size() - 1].known_kind = known_kind;
        end
        foreach (outs[i])
            pending_packets.push_back(outs[i]);
    endtask

    task automatic reg_write(input int index, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * index);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == lrss_pkg::REG_TIMEOUT)
            timeout_reg = value[15:0];
        else
            short_limit_reg = value[7:0];
    endtask

    // Offers one command word, holding it until it is taken. Random gaps come first.
    // The word stays offered afterwards until the caller drops valid or sends another.
    task automatic send_word(input lrss_pkg::item_t c, input bit has_known = 1'b0,
                             input logic [3:0] known_kind = lrss_pkg::PK_IDLE);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata <= {8'd0, c.short_sense, c.function_group, c.function_bits, c.direction,
                         c.step_count, c.speed_max, c.speed_is_percent, c.speed_request,
                         c.long_protocol, c.loco_address, c.now_ms, c.mode};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_packets(c, has_known, known_kind);
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending_packets.size() > 0)
            @(posedge clk);
        repeat (300)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic lrss_pkg::item_t blank_word(input logic [2:0] m);
        lrss_pkg::item_t c;
        c = '0;
        c.mode = m;
        return c;
    endfunction

    // Random content, mostly commands for a small pool of addresses so that slots are
    // revisited; the time stamp creeps forward so timeouts happen now and then.
    function automatic lrss_pkg::item_t random_word(input logic [31:0] now);
        lrss_pkg::item_t c;
        int    pick;
        c = '0;
        pick = $urandom_range(99);
        if (pick < 40)
            c.mode = lrss_pkg::MODE_TICK;
        else if (pick < 65)
            c.mode = lrss_pkg::MODE_LOCO;
        else if (pick < 80)
            c.mode = lrss_pkg::MODE_FUNC;
        else if (pick < 84)
            c.mode = lrss_pkg::MODE_PON;
        else if (pick < 86)
            c.mode = lrss_pkg::MODE_POFF;
        else if (pick < 98)
            c.mode = lrss_pkg::MODE_SHORT;
        else
            c.mode = 3'($urandom_range(7, 6));
        c.now_ms = ($urandom_range(49) == 0) ? $urandom() : now;
        c.loco_address = ($urandom_range(9) == 0) ? 14'($urandom()) : 14'($urandom_range(200));
        c.long_protocol = 1'($urandom_range(1));
        c.speed_request = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(140));
        c.speed_is_percent = 1'($urandom_range(1));
        c.speed_max = ($urandom_range(7) == 0) ? 15'($urandom()) : 15'($urandom_range(130));
        case ($urandom_range(4))
            0: c.step_count = 8'd14;
            1: c.step_count = 8'd28;
            2: c.step_count = 8'd128;
            default: c.step_count = 8'($urandom());
        endcase
        c.direction = 1'($urandom_range(1));
        c.function_bits = 29'($urandom());
        c.function_group = 3'($urandom());
        c.short_sense = ($urandom_range(3) != 0);
        return c;
    endfunction

    // Result side: random stalls, a long hold-off on request, and field checks.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            packet_t want;
            if (pending_packets.size() == 0)
            begin
                report_mismatch("unexpected word", m_axis_tdata[31:0], 32'd0);
            end
            else
            begin
                want = pending_packets.pop_front();
                if (m_axis_tdata[3:0] != want.kind)
                    report_mismatch("packet_kind", 32'(m_axis_tdata[3:0]), 32'(want.kind));
                if (m_axis_tdata[17:4] != want.address)
                    report_mismatch("out_address", 32'(m_axis_tdata[17:4]),
                                    32'(want.address));
                if (m_axis_tdata[18] != want.long_addr)
                    report_mismatch("out_long_address", 32'(m_axis_tdata[18]),
                                    32'(want.long_addr));
                if (m_axis_tdata[25:19] != want.speed)
                    report_mismatch("out_speed", 32'(m_axis_tdata[25:19]), 32'(want.speed));
                if (m_axis_tdata[26] != want.dir)
                    report_mismatch("out_direction", 32'(m_axis_tdata[26]), 32'(want.dir));
                if (m_axis_tdata[27] != want.lights)
                    report_mismatch("out_lights", 32'(m_axis_tdata[27]), 32'(want.lights));
                if (m_axis_tdata[56:28] != want.fbits)
                    report_mismatch("out_functions", 32'(m_axis_tdata[56:28]),
                                    32'(want.fbits));
                if (m_axis_tdata[57] != want.power)
                    report_mismatch("power_on", 32'(m_axis_tdata[57]), 32'(want.power));
                if (m_axis_tlast != want.last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
                // Directed rows with an at-a-glance kind are checked once more here.
                if (want.has_known && m_axis_tdata[3:0] != want.known_kind)
                    report_mismatch("directed kind", 32'(m_axis_tdata[3:0]),
                                    32'(want.known_kind));
            end
        end
    end

    // Watchdog: a long run of cycles without any word moving ends the run.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("loco_refresh_slot_scheduler_test: errors");
            $finish;
        end
    end

    initial
    begin
        row_t            rows[$];
        row_t            r;
        lrss_pkg::item_t c;
        logic [31:0]     now;
        int              phase;
        int              hold_len;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        clear_table();
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: power status, idle packet on an empty table, extremes of the
        // speed scaling, address zero, odd step counts, long addressing, every group.
        r.has_known = 1'b0;
        c = blank_word(lrss_pkg::MODE_TICK);
        r.cmd = c; r.known_kind = lrss_pkg::PK_IDLE; rows.push_back(r);   // power off: nothing
        c = blank_word(lrss_pkg::MODE_PON);
        r.cmd = c; r.known_kind = lrss_pkg::PK_POWER; r.has_known = 1'b1; rows.push_back(r);
        c = blank_word(lrss_pkg::MODE_TICK);
        r.cmd = c; r.known_kind = lrss_pkg::PK_IDLE; rows.push_back(r);
        r.has_known = 1'b0;
        c = blank_word(lrss_pkg::MODE_LOCO);
        c.loco_address = 14'd3; c.speed_request = 16'hFFFF; c.step_count = 8'd128;
        rows.push_back('{c, lrss_pkg::PK_IDLE, 1'b0});
        c = blank_word(lrss_pkg::MODE_LOCO);
        c.loco_address = 14'h3FFF; c.speed_request = 16'h7FFF; c.speed_is_percent = 1'b1;
        c.step_count = 8'hFF; c.direction = 1'b1; c.function_bits = 29'h1FFFFFFF;
        rows.push_back('{c, lrss_pkg::PK_IDLE, 1'b0});
        c = blank_word(lrss_pkg::MODE_LOCO);
        c.loco_address = 14'd100; c.speed_request = 16'd50; c.speed_max = 15'h7FFF;
        c.step_count = 8'd28; c.long_protocol = 1'b1;
        rows.push_back('{c, lrss_pkg::PK_IDLE, 1'b0});
        c = blank_word(lrss_pkg::MODE_LOCO);
        c.loco_address = 14'd101; c.speed_request = 16'd50; c.speed_max = 15'd0;
        c.step_count = 8'd14;
        rows.push_back('{c, lrss_pkg::PK_IDLE, 1'b0});
        c = blank_word(lrss_pkg::MODE_LOCO);
        c.loco_address = 14'd0; c.speed_request = 16'h8000; c.step_count = 8'd28;
        rows.push_back('{c, lrss_pkg::PK_IDLE, 1'b0});
        for (int g = 0; g < 8; g++)
        begin
            c = blank_word(lrss_pkg::MODE_FUNC);
            c.loco_address = (g == 7) ? 14'd200 : 14'd3;
            c.function_group = 3'(g);
            c.function_bits = 29'(32'h0A5A5A5 << g);
            rows.push_back('{c, lrss_pkg::PK_IDLE, 1'b0});
            c = blank_word(lrss_pkg::MODE_TICK);
            rows.push_back('{c, lrss_pkg::PK_IDLE, 1'b0});
        end
        c = blank_word(lrss_pkg::MODE_SHORT); c.short_sense = 1'b1;
        rows.push_back('{c, lrss_pkg::PK_IDLE, 1'b0});
        c = blank_word(lrss_pkg::MODE_POFF);
        rows.push_back('{c, lrss_pkg::PK_POWER, 1'b1});
        c = blank_word(3'd6);
        rows.push_back('{c, lrss_pkg::PK_IDLE, 1'b0});
        c = blank_word(3'd7);
        rows.push_back('{c, lrss_pkg::PK_IDLE, 1'b0});

        foreach (rows[i])
            send_word(rows[i].cmd, rows[i].has_known, rows[i].known_kind);
        s_axis_tvalid <= 1'b0;
        drain();

        // Random phases with differing idling and register settings, extremes included.
        now = 32'd1000;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            case (phase)
                0:
                begin
                    reg_write(lrss_pkg::REG_TIMEOUT, 32'd0);
                    reg_write(lrss_pkg::REG_SHORT, 32'd0);
                end
                1:
                begin
                    reg_write(lrss_pkg::REG_TIMEOUT, 32'd65535);
                    reg_write(lrss_pkg::REG_SHORT, 32'd255);
                end
                2:
                begin
                    reg_write(lrss_pkg::REG_TIMEOUT, 32'd40);
                    reg_write(lrss_pkg::REG_SHORT, 32'd3);
                end
                default:
                begin
                    reg_write(lrss_pkg::REG_TIMEOUT, $urandom_range(200));
                    reg_write(lrss_pkg::REG_SHORT, $urandom_range(255, 0));
                end
            endcase
            send_word(blank_word(lrss_pkg::MODE_PON));
            for (int k = 0; k < 100; k++)
            begin
                now = now + $urandom_range(20);
                send_word(random_word(now));
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end

        // Back-pressure: the receiver holds off while power words keep arriving.
        fork
            begin
                hold_off = 1'b1;
                hold_len = 0;
                while (hold_len < 400)
                begin
                    @(posedge clk);
                    hold_len++;
                end
                hold_off = 1'b0;
            end
            begin
                send_idle_pct = 0;
                for (int k = 0; k < 12; k++)
                    send_word(blank_word(($urandom_range(1) != 0) ? lrss_pkg::MODE_PON :
                                                                     lrss_pkg::MODE_POFF));
                s_axis_tvalid <= 1'b0;
            end
        join
        drain();

        if (error_count == 0)
            $display("loco_refresh_slot_scheduler_test: clean");
        else
            $display("loco_refresh_slot_scheduler_test: errors");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/lrss_pkg.sv
rtl/lrss_divider.sv
rtl/lrss_datapath.sv
rtl/lrss_controller.sv
rtl/loco_refresh_slot_scheduler.sv
rtl/lrss_checker.sv
test/loco_refresh_slot_scheduler_test.sv
